@@ src/bmd_pkg.sv @@
package bmd_pkg;

  // Fixed field widths
  localparam int unsigned PIX_W          = 16;
  localparam int unsigned SUM_W          = 24;
  localparam int unsigned FRAC_W         = 8;
  localparam int unsigned MEAN_W         = 24;
  localparam int unsigned ROW_W          = 12;
  localparam int unsigned MAX_IMAGE_COLS = 2048;
  localparam int unsigned MAX_IMAGE_ROWS = 4096;
  localparam int unsigned MAX_BLOCK      = 16;
  localparam int unsigned COL_W          = $clog2(MAX_IMAGE_COLS);
  localparam int unsigned IMG_ROWS_W     = 13;
  localparam int unsigned IMG_COLS_W     = 12;
  localparam int unsigned BLK_W          = 5;
  localparam int unsigned IN_BLK_W       = $clog2(MAX_BLOCK);
  localparam int unsigned CNT_W          = $clog2(MAX_BLOCK * MAX_BLOCK) + 1;
  localparam int unsigned DIVD_W         = SUM_W + FRAC_W;

  // Configuration port
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd3;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // One classified pixel on its way to the accumulator
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] slot;
    logic [ROW_W-1:0] out_row;
    logic [CNT_W-1:0] count;
    logic             emit;
    logic             frame_end;
  } item_t;

endpackage

@@ src/bmd_front.sv @@
module bmd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [bmd_pkg::PIX_W-1:0]        pixel_i,
  input  logic                             cfg_we_i,
  input  logic [bmd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bmd_pkg::CFG_W-1:0]        cfg_data_i,
  output bmd_pkg::item_t                   item_o
);
  import bmd_pkg::*;

  logic [BLK_W-1:0]      block_rows_q, block_cols_q;
  logic [IMG_ROWS_W-1:0] image_rows_q;
  logic [IMG_COLS_W-1:0] image_cols_q;

  logic [BLK_W-1:0]      br, bc;
  logic [IMG_ROWS_W-1:0] ir;
  logic [IMG_COLS_W-1:0] ic;

  logic [ROW_W-1:0]    row_pos_q, row_pos_d;
  logic [COL_W-1:0]    col_pos_q, col_pos_d;
  logic [IN_BLK_W-1:0] row_in_blk_q, row_in_blk_d;
  logic [IN_BLK_W-1:0] col_in_blk_q, col_in_blk_d;
  logic [COL_W-1:0]    blk_col_idx_q, blk_col_idx_d;
  logic [ROW_W-1:0]    blk_row_idx_q, blk_row_idx_d;

  logic col_last, row_last, blk_col_last, blk_row_last;
  logic [2*BLK_W-1:0] count_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_rows_q <= BLK_W'(2);
      block_cols_q <= BLK_W'(2);
      image_rows_q <= IMG_ROWS_W'(512);
      image_cols_q <= IMG_COLS_W'(512);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BLOCK_ROWS: block_rows_q <= cfg_data_i[BLK_W-1:0];
        REG_BLOCK_COLS: block_cols_q <= cfg_data_i[BLK_W-1:0];
        REG_IMAGE_ROWS: image_rows_q <= cfg_data_i[IMG_ROWS_W-1:0];
        REG_IMAGE_COLS: image_cols_q <= cfg_data_i[IMG_COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp register values into their legal ranges
  always_comb begin
    br = block_rows_q;
    if (block_rows_q == '0) br = BLK_W'(1);
    else if (block_rows_q > BLK_W'(MAX_BLOCK)) br = BLK_W'(MAX_BLOCK);
    bc = block_cols_q;
    if (block_cols_q == '0) bc = BLK_W'(1);
    else if (block_cols_q > BLK_W'(MAX_BLOCK)) bc = BLK_W'(MAX_BLOCK);
    ir = image_rows_q;
    if (image_rows_q == '0) ir = IMG_ROWS_W'(1);
    else if (image_rows_q > IMG_ROWS_W'(MAX_IMAGE_ROWS)) ir = IMG_ROWS_W'(MAX_IMAGE_ROWS);
    ic = image_cols_q;
    if (image_cols_q == '0) ic = IMG_COLS_W'(1);
    else if (image_cols_q > IMG_COLS_W'(MAX_IMAGE_COLS)) ic = IMG_COLS_W'(MAX_IMAGE_COLS);
  end

  assign col_last     = (IMG_COLS_W'(col_pos_q) + IMG_COLS_W'(1)) >= ic;
  assign row_last     = (IMG_ROWS_W'(row_pos_q) + IMG_ROWS_W'(1)) >= ir;
  assign blk_col_last = col_last || ((BLK_W'(col_in_blk_q) + BLK_W'(1)) >= bc);
  assign blk_row_last = row_last || ((BLK_W'(row_in_blk_q) + BLK_W'(1)) >= br);

  assign count_full = (BLK_W'(row_in_blk_q) + BLK_W'(1)) * (BLK_W'(col_in_blk_q) + BLK_W'(1));

  always_comb begin
    item_o.pixel     = pixel_i;
    item_o.slot      = blk_col_idx_q;
    item_o.out_row   = blk_row_idx_q;
    item_o.count     = count_full[CNT_W-1:0];
    item_o.emit      = blk_col_last && blk_row_last;
    item_o.frame_end = col_last && row_last;
  end

  // Advance raster and block positions
  always_comb begin
    row_pos_d     = row_pos_q;
    col_pos_d     = col_pos_q;
    row_in_blk_d  = row_in_blk_q;
    col_in_blk_d  = col_in_blk_q;
    blk_col_idx_d = blk_col_idx_q;
    blk_row_idx_d = blk_row_idx_q;
    if (col_last) begin
      col_pos_d     = '0;
      col_in_blk_d  = '0;
      blk_col_idx_d = '0;
      if (row_last) begin
        row_pos_d     = '0;
        row_in_blk_d  = '0;
        blk_row_idx_d = '0;
      end else begin
        row_pos_d = row_pos_q + ROW_W'(1);
        if (blk_row_last) begin
          row_in_blk_d  = '0;
          blk_row_idx_d = blk_row_idx_q + ROW_W'(1);
        end else begin
          row_in_blk_d = row_in_blk_q + IN_BLK_W'(1);
        end
      end
    end else begin
      col_pos_d = col_pos_q + COL_W'(1);
      if (blk_col_last) begin
        col_in_blk_d  = '0;
        blk_col_idx_d = blk_col_idx_q + COL_W'(1);
      end else begin
        col_in_blk_d = col_in_blk_q + IN_BLK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q     <= '0;
      col_pos_q     <= '0;
      row_in_blk_q  <= '0;
      col_in_blk_q  <= '0;
      blk_col_idx_q <= '0;
      blk_row_idx_q <= '0;
    end else if (accept_i) begin
      row_pos_q     <= row_pos_d;
      col_pos_q     <= col_pos_d;
      row_in_blk_q  <= row_in_blk_d;
      col_in_blk_q  <= col_in_blk_d;
      blk_col_idx_q <= blk_col_idx_d;
      blk_row_idx_q <= blk_row_idx_d;
    end
  end

endmodule

@@ src/bmd_queue.sv @@
module bmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bmd_pkg::item_t push_item_i,
  input  logic           pop_i,
  output bmd_pkg::item_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import bmd_pkg::*;

  item_t              slots_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   fill_q;

  assign full_o  = fill_q == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty_o = fill_q == '0;
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + (Q_PTR_W+1)'(1);
        2'b01:   fill_q <= fill_q - (Q_PTR_W+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

@@ src/bmd_div.sv @@
module bmd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bmd_pkg::DIVD_W-1:0]    dividend_i,
  input  logic [bmd_pkg::CNT_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [bmd_pkg::DIVD_W-1:0]    quotient_o
);
  import bmd_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVD_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [CNT_W:0]    trial;
  logic              fits;

  // One quotient bit per cycle, restoring
  assign trial      = {rem_q, quo_q[DIVD_W-1]};
  assign fits       = trial >= {1'b0, div_q};
  assign done_o     = busy_q && (step_q == STEP_W'(DIVD_W - 1));
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (done_o) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= CNT_W'(trial - {1'b0, div_q});
      end else begin
        rem_q <= trial[CNT_W-1:0];
      end
      quo_q <= {quo_q[DIVD_W-2:0], fits};
    end
  end

endmodule

@@ src/bmd_back.sv @@
module bmd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bmd_pkg::item_t                head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bmd_pkg::MEAN_W-1:0]    mean_o,
  output logic [bmd_pkg::ROW_W-1:0]     out_row_o,
  output logic [bmd_pkg::COL_W-1:0]     out_col_o,
  output logic                          frame_end_o
);
  import bmd_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [COL_W-1:0] clr_addr_q;
  item_t            cur_q;

  logic [SUM_W-1:0] sums [MAX_IMAGE_COLS];
  logic [SUM_W-1:0] rdata_q;
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  logic [SUM_W-1:0] mem_wdata;

  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_sat;
  logic              div_start, div_done;
  logic [DIVD_W-1:0] quotient;
  logic [MEAN_W-1:0] mean_sat;
  logic              out_free;

  logic              out_valid_q;
  logic [MEAN_W-1:0] mean_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic              frame_end_q;

  assign sum_wide = {1'b0, rdata_q} + (SUM_W+1)'(cur_q.pixel);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign mean_sat = (quotient > DIVD_W'(SUM_MAX)) ? SUM_MAX : quotient[MEAN_W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  assign clearing_o = state_q == ST_CLEAR;
  assign pop_o      = (state_q == ST_IDLE) && !empty_i;
  assign div_start  = (state_q == ST_READ) && cur_q.emit;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q.slot;
    mem_wdata = sum_sat;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (state_q == ST_READ) begin
      mem_we = 1'b1;
      if (cur_q.emit) mem_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) sums[mem_waddr] <= mem_wdata;
    rdata_q <= sums[head_i.slot];
  end

  bmd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_sat, FRAC_W'(0)}),
    .divisor_i  (cur_q.count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_addr_q == COL_W'(MAX_IMAGE_COLS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (!empty_i) state_d = ST_READ;
      ST_READ:  state_d = cur_q.emit ? ST_DIV : ST_IDLE;
      ST_DIV:   if (div_done) state_d = ST_HOLD;
      ST_HOLD:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + COL_W'(1);
      if (state_q == ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (state_q == ST_HOLD && out_free) begin
      mean_q      <= mean_sat;
      out_row_q   <= cur_q.out_row;
      out_col_q   <= cur_q.slot;
      frame_end_q <= cur_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign frame_end_o = frame_end_q;

endmodule

@@ src/block_mean_downscaler_unit.sv @@
// Channel | Handshake                  | Payload
// --------+----------------------------+----------------------------------------
// in      | in_valid_i / in_stall_o    | pixel_i
// out     | out_valid_o / out_stall_i  | mean_o, out_row_o, out_col_o, frame_end_o
// cfg     | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// The front end takes one pixel a cycle into a four-beat queue while room is left.
// The back end spends an accumulator read-modify-write on each pixel (IDLE, READ);
// a pixel that closes a block also runs the bit-serial divider (DIV) and then
// loads the output register (HOLD).
// After reset all 2048 entries of the accumulator memory are cleared; in_stall_o
// stays high for that pass. Output stalls hold only the back end at a block end.
module block_mean_downscaler_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bmd_pkg::PIX_W-1:0]      pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bmd_pkg::MEAN_W-1:0]     mean_o,
  output logic [bmd_pkg::ROW_W-1:0]      out_row_o,
  output logic [bmd_pkg::COL_W-1:0]      out_col_o,
  output logic                           frame_end_o,
  input  logic                           cfg_we_i,
  input  logic [bmd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmd_pkg::CFG_W-1:0]      cfg_data_i
);
  import bmd_pkg::*;

  item_t front_item, head_item;
  logic  accept, q_full, q_empty, pop, clearing;

  // Hold input off while the queue is full or the memory is being cleared
  assign in_stall_o = q_full || clearing;
  assign accept     = in_valid_i && !in_stall_o;

  // Front: config registers, raster/block positions, per-beat classification
  bmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pixel_i     (pixel_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_o      (front_item)
  );

  // Decouple the front from the accumulator back end
  bmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_item_i (front_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Back: column accumulators, divider and output register
  bmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_item),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_o      (mean_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_end_o (frame_end_o)
  );

endmodule
